[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define MSE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MSE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/mse_pkg.sv]
`timescale 1ns / 1ps

package mse_pkg;

	// Item operations
	localparam logic [1:0] OP_EXEC = 2'd0;
	localparam logic [1:0] OP_WRB  = 2'd1;
	localparam logic [1:0] OP_RDB  = 2'd2;

	// Primary opcodes; anything else executes as addiu
	localparam logic [5:0] OPC_RTYPE = 6'h00;
	localparam logic [5:0] OPC_J     = 6'h02;
	localparam logic [5:0] OPC_BEQ   = 6'h04;
	localparam logic [5:0] OPC_LW    = 6'h23;
	localparam logic [5:0] OPC_SW    = 6'h2B;

	// R-type function codes
	localparam logic [5:0] FN_ADDU = 6'h21;
	localparam logic [5:0] FN_SUBU = 6'h23;
	localparam logic [5:0] FN_AND  = 6'h24;
	localparam logic [5:0] FN_OR   = 6'h25;
	localparam logic [5:0] FN_NOR  = 6'h27;

	localparam logic [31:0] HALT_WORD = 32'hFFFF_FFFF;

	// Data memory access, one lane per byte bank
	typedef struct packed {
		logic       rd;
		logic       wr;
		logic [3:0] lane_en;
	} mse_mem_ctl_t;

	// Register file write port
	typedef struct packed {
		logic        en;
		logic [4:0]  idx;
		logic [31:0] data;
	} mse_rf_wr_t;

endpackage

[rtl/mips_subset_instruction_executor.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel | Handshake          | Word fields
// --------+--------------------+--------------------------------------------------------
// in      | in_valid/in_stall  | operation, instruction, byte_address, byte_value
// out     | out_valid/out_stall| next_pc, reg_write_enable/index/value, halted, read_byte
//
// One word per cycle while the output is not stalled; an accepted word is registered in stage 1
// (execute on operands read at acceptance), then stage 2 (memory data) and the output register.
// After reset the data memory is swept to zero, one row of four bytes per cycle;
// in_stall stays high until the sweep ends.
// A stalled output holds its word; the pipeline behind it fills and then stalls the input.
// Writeback forwards into execute, so dependent words, loads included, need no bubbles.

module mips_subset_instruction_executor
	import mse_pkg::*;
#(
	parameter int DATA_BYTES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [31:0] instruction,
	input  logic [15:0] byte_address,
	input  logic [7:0]  byte_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] next_pc,
	output logic        reg_write_enable,
	output logic [4:0]  reg_write_index,
	output logic [31:0] reg_write_value,
	output logic        halted,
	output logic [7:0]  read_byte
);

	// DATA_BYTES is a power of two, so a byte address wraps by truncation
	localparam int AW    = $clog2(DATA_BYTES);
	localparam int ROW_W = AW - 2;

	// ---------------------------------------------------------------- handshake
	logic acc, mv1, ld_out;
	logic s1_free, s2_free;
	logic s1_v, s2_v, out_valid_q;
	logic mem_ready;

	assign ld_out   = s2_v && (!out_valid_q || !out_stall);
	assign s2_free  = !s2_v || ld_out;
	assign mv1      = s1_v && s2_free;
	assign s1_free  = !s1_v || mv1;
	// hold the input while memory clears or execute is occupied
	assign in_stall = !mem_ready || !s1_free;
	assign acc      = in_valid && !in_stall;

	// ---------------------------------------------------------------- stage 1 (read)
	logic [1:0]  op_s1;
	logic [31:0] instr_s1;
	logic [15:0] baddr_s1;
	logic [7:0]  bval_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else if (s1_free) begin
			s1_v <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1    <= operation;
			instr_s1 <= instruction;
			baddr_s1 <= byte_address;
			bval_s1  <= byte_value;
		end
	end

	// Register file reads launch with acceptance, data arrives in stage 1
	mse_rf_wr_t  rf_wr;
	logic [31:0] rf_qa, rf_qb;

	mse_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (acc),
		.rd_idx_a  (instruction[25:21]),
		.rd_idx_b  (instruction[20:16]),
		.wr        (rf_wr),
		.rd_data_a (rf_qa),
		.rd_data_b (rf_qb)
	);

	// ---------------------------------------------------------------- stage 2 state
	logic [31:0] pc_s2, val_s2;
	logic        we_s2, load_s2, rdb_s2, halt_s2;
	logic [4:0]  idx_s2;
	logic [1:0]  lane_s2;
	logic [31:0] val2;

	// ---------------------------------------------------------------- execute
	logic [31:0] pc_q;
	logic        halt_q;
	logic [5:0]  opcode, funct;
	logic [4:0]  rs, rt, rd;
	logic [31:0] sext, a, b, pc4, ea, br_tgt, jmp_tgt;
	logic [31:0] pc_new, val1;
	logic        halt_new, we1, load1, rdb1;
	logic [4:0]  idx1;
	logic [1:0]  lane1, off;
	logic [ROW_W-1:0]      row0;
	mse_mem_ctl_t          mem_ctl;
	logic [3:0][ROW_W-1:0] mem_row;
	logic [3:0][7:0]       mem_wdata, mem_rdata;

	assign opcode = instr_s1[31:26];
	assign rs     = instr_s1[25:21];
	assign rt     = instr_s1[20:16];
	assign rd     = instr_s1[15:11];
	assign funct  = instr_s1[5:0];
	assign sext   = {{16{instr_s1[15]}}, instr_s1[15:0]};

	// forward the word now in writeback; older words are already in the file
	assign a = (s2_v && we_s2 && idx_s2 == rs) ? val2 : rf_qa;
	assign b = (s2_v && we_s2 && idx_s2 == rt) ? val2 : rf_qb;

	assign pc4     = pc_q + 32'd4;
	assign ea      = a + sext;
	assign br_tgt  = pc4 + {sext[29:0], 2'b00};
	assign jmp_tgt = {pc4[31:28], instr_s1[25:0], 2'b00};
	assign off     = ea[1:0];
	assign row0    = ea[AW-1:2];

	always_comb begin
		pc_new   = pc_q;
		halt_new = halt_q;
		we1      = 1'b0;
		load1    = 1'b0;
		rdb1     = 1'b0;
		idx1     = '0;
		val1     = '0;
		lane1    = baddr_s1[1:0];
		mem_ctl  = '0;
		if (op_s1 == OP_EXEC && !halt_q) begin
			pc_new = pc4;
			lane1  = off;
			if (instr_s1 == HALT_WORD) begin
				halt_new = 1'b1;
			end else begin
				case (opcode)
					OPC_J: begin
						pc_new = jmp_tgt;
					end
					OPC_BEQ: begin
						if (a == b) begin
							pc_new = br_tgt;
						end
					end
					OPC_SW: begin
						mem_ctl.wr      = 1'b1;
						mem_ctl.lane_en = 4'hF;
					end
					OPC_RTYPE: begin
						idx1 = rd;
						we1  = 1'b1;
						case (funct)
							FN_ADDU: val1 = a + b;
							FN_SUBU: val1 = a - b;
							FN_AND:  val1 = a & b;
							FN_OR:   val1 = a | b;
							FN_NOR:  val1 = ~(a | b);
							default: we1  = 1'b0;
						endcase
					end
					OPC_LW: begin
						idx1            = rt;
						we1             = 1'b1;
						load1           = 1'b1;
						mem_ctl.rd      = 1'b1;
						mem_ctl.lane_en = 4'hF;
					end
					default: begin
						// addiu, and every opcode not decoded above
						idx1 = rt;
						we1  = 1'b1;
						val1 = ea;
					end
				endcase
			end
		end else if (op_s1 == OP_WRB) begin
			mem_ctl.wr      = 1'b1;
			mem_ctl.lane_en = 4'b0001 << baddr_s1[1:0];
		end else if (op_s1 == OP_RDB) begin
			mem_ctl.rd = 1'b1;
			rdb1       = 1'b1;
		end
		// drop writes to register zero and report them as no write
		if (!we1 || idx1 == 5'd0) begin
			we1   = 1'b0;
			load1 = 1'b0;
			idx1  = '0;
			val1  = '0;
		end
		// touch memory only as the word leaves execute
		mem_ctl.rd = mem_ctl.rd && mv1;
		mem_ctl.wr = mem_ctl.wr && mv1;
	end

	// Spread a word access over the four byte banks; big-endian byte i sits at ea + i
	always_comb begin : p_lanes
		logic [1:0] ln;
		logic [1:0] bi;
		for (int k = 0; k < 4; k++) begin
			ln = 2'(k);
			bi = ln - off;
			if (op_s1 == OP_EXEC) begin
				mem_row[k]   = row0 + ROW_W'(ln < off);
				mem_wdata[k] = b[{~bi, 3'b000} +: 8];
			end else begin
				mem_row[k]   = baddr_s1[AW-1:2];
				mem_wdata[k] = bval_s1;
			end
		end
	end

	mse_dmem #(
		.ROW_W (ROW_W)
	) u_dmem (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mem_ctl),
		.row    (mem_row),
		.wdata  (mem_wdata),
		.rdata  (mem_rdata),
		.ready  (mem_ready)
	);

	// Architectural state advances with the word leaving execute
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= '0;
			halt_q <= 1'b0;
		end else if (mv1) begin
			pc_q   <= pc_new;
			halt_q <= halt_new;
		end
	end

	// ---------------------------------------------------------------- stage 2 (writeback)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v <= 1'b0;
		end else if (s2_free) begin
			s2_v <= mv1;
		end
	end

	always_ff @(posedge clk) begin
		if (mv1) begin
			pc_s2   <= pc_new;
			we_s2   <= we1;
			idx_s2  <= idx1;
			val_s2  <= val1;
			load_s2 <= load1;
			rdb_s2  <= rdb1;
			lane_s2 <= lane1;
			halt_s2 <= halt_new;
		end
	end

	logic [31:0] ld_word;
	logic [7:0]  rbyte2;

	// Rotate the bank outputs back into big-endian order
	always_comb begin : p_load
		logic [1:0] ln;
		ld_word = '0;
		for (int i = 0; i < 4; i++) begin
			ln = lane_s2 + 2'(i);
			ld_word[{~2'(i), 3'b000} +: 8] = mem_rdata[ln];
		end
	end

	assign val2   = load_s2 ? ld_word : val_s2;
	assign rbyte2 = rdb_s2 ? mem_rdata[lane_s2] : '0;

	assign rf_wr.en   = ld_out && we_s2;
	assign rf_wr.idx  = idx_s2;
	assign rf_wr.data = val2;

	// ---------------------------------------------------------------- output register
	logic [31:0] out_pc_q, out_val_q;
	logic        out_we_q, out_halt_q;
	logic [4:0]  out_idx_q;
	logic [7:0]  out_byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= s2_v;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			out_pc_q   <= pc_s2;
			out_we_q   <= we_s2;
			out_idx_q  <= idx_s2;
			out_val_q  <= val2;
			out_halt_q <= halt_s2;
			out_byte_q <= rbyte2;
		end
	end

	assign out_valid        = out_valid_q;
	assign next_pc          = out_pc_q;
	assign reg_write_enable = out_we_q;
	assign reg_write_index  = out_idx_q;
	assign reg_write_value  = out_val_q;
	assign halted           = out_halt_q;
	assign read_byte        = out_byte_q;

	`MSE_ASSERT_NEXT(a_halt_sticks, halt_q, halt_q, "halt flag dropped")
	`MSE_ASSERT_NEXT(a_halt_holds_pc, halt_q, $stable(pc_q), "pc moved while halted")
	`MSE_ASSERT_NOW(a_no_r0_write, out_valid_q && out_we_q, out_idx_q != 5'd0, "write to register zero")

endmodule

[rtl/mse_regfile.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mse_regfile
	import mse_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         rd_en,
	input  logic [4:0]   rd_idx_a,
	input  logic [4:0]   rd_idx_b,
	input  mse_rf_wr_t   wr,
	output logic [31:0]  rd_data_a,
	output logic [31:0]  rd_data_b
);

	logic [31:0] mem [32];
	logic [31:0] valid_q;
	logic [31:0] da_q, db_q;
	logic        va_q, vb_q;
	logic        hit_a, hit_b;

	assign hit_a = wr.en && (wr.idx == rd_idx_a);
	assign hit_b = wr.en && (wr.idx == rd_idx_b);

	// Write-first: a read at the edge of a write to the same entry sees the new data
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx] <= wr.data;
		end
		if (rd_en) begin
			da_q <= hit_a ? wr.data : mem[rd_idx_a];
			db_q <= hit_b ? wr.data : mem[rd_idx_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			va_q    <= 1'b0;
			vb_q    <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.idx] <= 1'b1;
			end
			if (rd_en) begin
				va_q <= hit_a || valid_q[rd_idx_a];
				vb_q <= hit_b || valid_q[rd_idx_b];
			end
		end
	end

	// Never-written entries read as zero
	assign rd_data_a = va_q ? da_q : '0;
	assign rd_data_b = vb_q ? db_q : '0;

	`MSE_ASSERT_NEXT(a_rf_wr_marks_valid, wr.en, valid_q[$past(wr.idx)], "written entry not valid")

endmodule

[rtl/mse_dmem.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mse_dmem
	import mse_pkg::*;
#(
	parameter int ROW_W = 14
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mse_mem_ctl_t           ctl,
	input  logic [3:0][ROW_W-1:0]  row,
	input  logic [3:0][7:0]        wdata,
	output logic [3:0][7:0]        rdata,
	output logic                   ready
);

	localparam int ROWS = 1 << ROW_W;

	typedef enum logic [1:0] {
		ST_CLEAR = 2'b01,
		ST_RUN   = 2'b10
	} mse_clr_state_t;

	mse_clr_state_t   state_q;
	logic [ROW_W-1:0] clr_q;

	// Sweep one row of all four banks per cycle after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ROW_W'(1);
					if (clr_q == ROW_W'(ROWS - 1)) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					state_q <= ST_RUN;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	assign ready = (state_q == ST_RUN);

	for (genvar k = 0; k < 4; k++) begin : g_bank
		logic [7:0] bank [ROWS];

		always_ff @(posedge clk) begin
			if (state_q == ST_CLEAR) begin
				bank[clr_q] <= '0;
			end else if (ctl.wr && ctl.lane_en[k]) begin
				bank[row[k]] <= wdata[k];
			end
			if (ctl.rd) begin
				rdata[k] <= bank[row[k]];
			end
		end
	end

	`MSE_ASSERT_NOW(a_dmem_idle_in_clear, state_q == ST_CLEAR, !ctl.wr && !ctl.rd, "access during clear")

endmodule

[bench/mips_subset_instruction_executor_test.sv]
`timescale 1ns / 1ps

// Self-checking bench for the MIPS subset executor.
// Words are queued up front, driven in bursts and checked in order
// against a cycle-free model of the processor state.
module mips_subset_instruction_executor_test;
	import mse_pkg::*;

	// Operation code with no function; the block must report it as an idle word
	localparam logic [1:0] OP_SPARE = 2'd3;
	// Plain addiu opcode; every unclaimed opcode behaves the same way
	localparam logic [5:0] OPC_ADDIU = 6'h09;

	localparam logic [31:0] MEM_BYTES = 32'd65536;
	localparam int RANDOM_WORDS = 2000;
	localparam int HOLD_AFTER_RESULTS = 300;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 20;
	// Memory sweep after reset plus about 2030 words at
	// worst-case gaps and stalls, then taken several times over
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] instruction;
		logic [15:0] byte_address;
		logic [7:0]  byte_value;
	} exec_word_t;

	typedef struct packed {
		logic [31:0] next_pc;
		logic        reg_write_enable;
		logic [4:0]  reg_write_index;
		logic [31:0] reg_write_value;
		logic        halted;
		logic [7:0]  read_byte;
	} exec_result_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  operation = OP_EXEC;
	logic [31:0] instruction = '0;
	logic [15:0] byte_address = '0;
	logic [7:0]  byte_value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] next_pc;
	logic        reg_write_enable;
	logic [4:0]  reg_write_index;
	logic [31:0] reg_write_value;
	logic        halted;
	logic [7:0]  read_byte;

	// Model of the architectural state
	bit [31:0] model_pc;
	bit [31:0] model_regs [32];
	bit [7:0]  model_mem [65536];
	bit        model_halted;

	exec_word_t   words_to_send [$];
	exec_result_t results_due [$];
	exec_word_t   word_on_bus;
	exec_result_t oldest_due;

	int burst_left = 8;
	int gap_left = 0;
	int results_seen = 0;
	int error_count = 0;
	int cycle_count = 0;
	int stall_mode = 0;
	int mode_left = 50;
	int hold_left = 0;
	bit hold_done = 1'b0;

	mips_subset_instruction_executor u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.instruction(instruction),
		.byte_address(byte_address),
		.byte_value(byte_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.next_pc(next_pc),
		.reg_write_enable(reg_write_enable),
		.reg_write_index(reg_write_index),
		.reg_write_value(reg_write_value),
		.halted(halted),
		.read_byte(read_byte)
	);

	// Advance the model by one word and return the result it reports.
	function automatic exec_result_t execute_word(input exec_word_t w);
		exec_result_t r;
		logic [31:0] pc_plus4;
		logic [31:0] rs_val;
		logic [31:0] rt_val;
		logic [31:0] imm_ext;
		logic [31:0] addr;
		logic [31:0] wr_val;
		logic [5:0]  opcode;
		logic [4:0]  wr_idx;
		logic        wr_en;
		r = '0;
		wr_en = 1'b0;
		wr_idx = '0;
		wr_val = '0;
		case (w.operation)
			OP_WRB: model_mem[w.byte_address % MEM_BYTES] = w.byte_value;
			OP_RDB: r.read_byte = model_mem[w.byte_address % MEM_BYTES];
			OP_EXEC: if (!model_halted) begin
				pc_plus4 = model_pc + 32'd4;
				opcode = w.instruction[31:26];
				rs_val = model_regs[w.instruction[25:21]];
				rt_val = model_regs[w.instruction[20:16]];
				imm_ext = {{16{w.instruction[15]}}, w.instruction[15:0]};
				addr = rs_val + imm_ext;
				if (w.instruction == HALT_WORD) begin
					model_halted = 1'b1;
					model_pc = pc_plus4;
				end else if (opcode == OPC_J) begin
					model_pc = {pc_plus4[31:28], w.instruction[25:0], 2'b00};
				end else if (opcode == OPC_BEQ) begin
					model_pc = (rs_val == rt_val) ? pc_plus4 + (imm_ext << 2) : pc_plus4;
				end else if (opcode == OPC_SW) begin
					// Big-endian: the most significant byte lands at the lowest address
					for (int i = 0; i < 4; i++)
						model_mem[(addr + i) % MEM_BYTES] = rt_val[31 - 8 * i -: 8];
					model_pc = pc_plus4;
				end else begin
					wr_en = 1'b1;
					if (opcode == OPC_RTYPE) begin
						wr_idx = w.instruction[15:11];
						case (w.instruction[5:0])
							FN_ADDU: wr_val = rs_val + rt_val;
							FN_SUBU: wr_val = rs_val - rt_val;
							FN_AND:  wr_val = rs_val & rt_val;
							FN_OR:   wr_val = rs_val | rt_val;
							FN_NOR:  wr_val = ~(rs_val | rt_val);
							default: wr_en = 1'b0;
						endcase
					end else if (opcode == OPC_LW) begin
						wr_idx = w.instruction[20:16];
						for (int i = 0; i < 4; i++)
							wr_val = {wr_val[23:0], model_mem[(addr + i) % MEM_BYTES]};
					end else begin
						wr_idx = w.instruction[20:16];
						wr_val = addr;
					end
					// Drop writes to register zero and report them as no write
					if (wr_en && wr_idx != 5'd0) begin
						model_regs[wr_idx] = wr_val;
					end else begin
						wr_en = 1'b0;
						wr_idx = '0;
						wr_val = '0;
					end
					model_pc = pc_plus4;
				end
			end
			default: ;
		endcase
		r.next_pc = model_pc;
		r.reg_write_enable = wr_en;
		r.reg_write_index = wr_idx;
		r.reg_write_value = wr_val;
		r.halted = model_halted;
		return r;
	endfunction

	task automatic queue_word(input logic [1:0] op, input logic [31:0] instr,
			input logic [15:0] addr, input logic [7:0] value);
		words_to_send.push_back('{op, instr, addr, value});
	endtask

	function automatic logic [31:0] r_word(input logic [4:0] rs, input logic [4:0] rt,
			input logic [4:0] rd, input logic [5:0] fn);
		return {OPC_RTYPE, rs, rt, rd, 5'd0, fn};
	endfunction

	function automatic logic [31:0] i_word(input logic [5:0] opc, input logic [4:0] rs,
			input logic [4:0] rt, input logic [15:0] imm);
		return {opc, rs, rt, imm};
	endfunction

	// Favor a few low registers so results feed later words
	function automatic logic [4:0] pick_reg();
		return ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
	endfunction

	function automatic logic [31:0] random_instruction();
		logic [31:0] w;
		logic [5:0]  opc;
		logic [5:0]  fn;
		logic [4:0]  rs;
		logic [4:0]  rt;
		int          kind;
		kind = $urandom_range(0, 99);
		rs = pick_reg();
		rt = pick_reg();
		if (kind < 35) begin
			case ($urandom_range(0, 5))
				0: fn = FN_ADDU;
				1: fn = FN_SUBU;
				2: fn = FN_AND;
				3: fn = FN_OR;
				4: fn = FN_NOR;
				default: fn = 6'($urandom);
			endcase
			w = {OPC_RTYPE, rs, rt, pick_reg(), 5'($urandom), fn};
		end else if (kind < 55) begin
			opc = ($urandom_range(0, 1) == 0) ? OPC_ADDIU : 6'($urandom);
			if (opc == OPC_RTYPE || opc == OPC_J || opc == OPC_BEQ || opc == OPC_LW ||
					opc == OPC_SW)
				opc = OPC_ADDIU;
			w = i_word(opc, rs, rt, 16'($urandom));
		end else if (kind < 68) begin
			w = i_word(OPC_LW, rs, rt, 16'($urandom));
		end else if (kind < 80) begin
			w = i_word(OPC_SW, rs, rt, 16'($urandom));
		end else if (kind < 92) begin
			// Equal operands half the time so branches get taken
			if ($urandom_range(0, 1) == 0)
				rt = rs;
			w = i_word(OPC_BEQ, rs, rt, 16'($urandom));
		end else begin
			w = {OPC_J, 26'($urandom)};
		end
		// Keep the halt word for the end of the run
		if (w == HALT_WORD)
			w[0] = 1'b0;
		return w;
	endfunction

	task automatic check_field(input string field, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			error_count++;
			if (error_count <= MAX_REPORTS)
				$display("result %0d, %s: expected %h, got %h", results_seen, field, want, got);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Stimulus: build the whole word list, release reset, then wait for the drain
	initial begin
		logic [15:0] base;
		logic [4:0]  rs;
		logic [4:0]  rt;
		logic [15:0] imm;
		int          kind;

		// Byte preload and readback at both ends of the memory
		queue_word(OP_WRB, 32'h0, 16'h0000, 8'hFF);
		queue_word(OP_WRB, 32'h0, 16'hFFFF, 8'h80);
		queue_word(OP_RDB, 32'h0, 16'hFFFF, 8'h00);
		queue_word(OP_RDB, 32'h0, 16'h0000, 8'h00);
		// addiu with the largest positive and negative immediates, and an
		// unclaimed opcode that must act as addiu
		queue_word(OP_EXEC, i_word(OPC_ADDIU, 5'd0, 5'd1, 16'h7FFF), '0, '0);
		queue_word(OP_EXEC, i_word(OPC_ADDIU, 5'd0, 5'd2, 16'h8000), '0, '0);
		queue_word(OP_EXEC, i_word(6'h3F, 5'd0, 5'd3, 16'hFFFF), '0, '0);
		// Every R-type function, an unknown function, and a write to register zero
		queue_word(OP_EXEC, r_word(5'd1, 5'd2, 5'd4, FN_ADDU), '0, '0);
		queue_word(OP_EXEC, r_word(5'd0, 5'd1, 5'd5, FN_SUBU), '0, '0);
		queue_word(OP_EXEC, r_word(5'd3, 5'd1, 5'd6, FN_AND), '0, '0);
		queue_word(OP_EXEC, r_word(5'd1, 5'd2, 5'd7, FN_OR), '0, '0);
		queue_word(OP_EXEC, r_word(5'd0, 5'd0, 5'd8, FN_NOR), '0, '0);
		queue_word(OP_EXEC, r_word(5'd1, 5'd3, 5'd9, 6'h20), '0, '0);
		queue_word(OP_EXEC, r_word(5'd3, 5'd3, 5'd0, FN_ADDU), '0, '0);
		// Unaligned word accesses that wrap past the top of memory, then an aligned load
		queue_word(OP_EXEC, i_word(OPC_SW, 5'd0, 5'd3, 16'hFFFE), '0, '0);
		queue_word(OP_EXEC, i_word(OPC_LW, 5'd0, 5'd10, 16'hFFFF), '0, '0);
		queue_word(OP_EXEC, i_word(OPC_LW, 5'd2, 5'd11, 16'h0000), '0, '0);
		// Branch taken, not taken, and with the most negative offset
		queue_word(OP_EXEC, i_word(OPC_BEQ, 5'd0, 5'd0, 16'h0001), '0, '0);
		queue_word(OP_EXEC, i_word(OPC_BEQ, 5'd1, 5'd2, 16'hFFFF), '0, '0);
		queue_word(OP_EXEC, i_word(OPC_BEQ, 5'd0, 5'd0, 16'h8000), '0, '0);
		// Jumps to the extremes of the target field
		queue_word(OP_EXEC, {OPC_J, 26'h3FF_FFFF}, '0, '0);
		queue_word(OP_EXEC, {OPC_J, 26'h000_0000}, '0, '0);
		// The spare operation carries junk that must be ignored
		queue_word(OP_SPARE, 32'hDEAD_BEEF, 16'h1234, 8'h5A);
		queue_word(OP_RDB, 32'h0, 16'h0001, 8'h00);

		// Random part: half loose instructions with random content, the rest byte traffic
		// and short store and load sequences
		while (words_to_send.size() < 24 + RANDOM_WORDS) begin
			kind = $urandom_range(0, 99);
			base = 16'($urandom);
			rs = pick_reg();
			rt = pick_reg();
			imm = 16'($urandom);
			if (kind < 50) begin
				queue_word(OP_EXEC, random_instruction(), 16'($urandom), 8'($urandom));
			end else if (kind < 60) begin
				queue_word(OP_WRB, 32'($urandom), base, 8'($urandom));
			end else if (kind < 68) begin
				queue_word(OP_RDB, 32'($urandom), base, 8'($urandom));
			end else if (kind < 80) begin
				// Preload four bytes, then load them as a word off register zero
				for (int i = 0; i < 4; i++)
					queue_word(OP_WRB, '0, base + 16'(i), 8'($urandom));
				queue_word(OP_EXEC, i_word(OPC_LW, 5'd0, rt, base), '0, '0);
			end else if (kind < 90) begin
				// Store a word, then read its bytes back one by one
				queue_word(OP_EXEC, i_word(OPC_SW, 5'd0, rt, base), '0, '0);
				for (int i = 0; i < 4; i++)
					queue_word(OP_RDB, '0, base + 16'(i), '0);
			end else begin
				// Store and load back through the same base and offset
				queue_word(OP_EXEC, i_word(OPC_SW, rs, rt, imm), '0, '0);
				queue_word(OP_EXEC, i_word(OPC_LW, rs, pick_reg(), imm), '0, '0);
			end
		end

		// Halt last: execute words then change nothing, byte access still works
		queue_word(OP_EXEC, HALT_WORD, '0, '0);
		for (int i = 0; i < 3; i++)
			queue_word(OP_EXEC, random_instruction(), '0, '0);
		queue_word(OP_WRB, '0, 16'h4321, 8'hA5);
		queue_word(OP_RDB, '0, 16'h4321, '0);
		queue_word(OP_EXEC, HALT_WORD, '0, '0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (words_to_send.size() != 0 || in_valid || results_due.size() != 0)
			@(posedge clk);
		// Catch any stray result after the last expected one
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Driver: predict on acceptance, then hold the word or load the next one.
	// Bursts of random length alternate with random gaps, some gaps empty.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			operation <= OP_EXEC;
			instruction <= '0;
			byte_address <= '0;
			byte_value <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				results_due.push_back(execute_word(word_on_bus));
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
			// Hold a stalled word; otherwise idle out the gap or present the next one
			if (!in_valid || !in_stall) begin
				if (gap_left > 0 || words_to_send.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					in_valid <= 1'b0;
				end else begin
					word_on_bus = words_to_send.pop_front();
					in_valid <= 1'b1;
					operation <= word_on_bus.operation;
					instruction <= word_on_bus.instruction;
					byte_address <= word_on_bus.byte_address;
					byte_value <= word_on_bus.byte_value;
				end
			end
		end
	end

	// Receiver stall: random modes (free, light, heavy), plus one long hold-off
	// mid-run so the pipeline fills and pushes back on the input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (!hold_done && results_seen >= HOLD_AFTER_RESULTS) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					stall_mode = $urandom_range(0, 2);
					mode_left = $urandom_range(20, 150);
				end else begin
					mode_left--;
				end
				case (stall_mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					default: out_stall <= ($urandom_range(0, 9) < 7);
				endcase
			end
		end
	end

	// Monitor: compare every accepted result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (results_due.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("result %0d arrived with nothing expected", results_seen);
			end else begin
				oldest_due = results_due.pop_front();
				check_field("next_pc", next_pc, oldest_due.next_pc);
				check_field("reg_write_enable", 32'(reg_write_enable),
					32'(oldest_due.reg_write_enable));
				check_field("reg_write_index", 32'(reg_write_index),
					32'(oldest_due.reg_write_index));
				check_field("reg_write_value", reg_write_value, oldest_due.reg_write_value);
				check_field("halted", 32'(halted), 32'(oldest_due.halted));
				check_field("read_byte", 32'(read_byte), 32'(oldest_due.read_byte));
			end
			results_seen++;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

endmodule
